>>> rtl/core/lpk_pkg.sv
// ----------------------------------------------------------------------------
// lpk_pkg: shared types and constants for the list blob stream parser
// Transfer payload structs, phase and code enums, encoding byte values and
// the trailer size function.
// ----------------------------------------------------------------------------
`default_nettype none

package lpk_pkg;

  // parser phases
  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_ENC     = 3'd1,
    PH_FIELD   = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_TRAILER = 3'd4,
    PH_DONE    = 3'd5
  } phase_t;

  // result kinds
  typedef enum logic [2:0] {
    KIND_INT     = 3'd0,
    KIND_STR_HDR = 3'd1,
    KIND_PAYLOAD = 3'd2,
    KIND_END     = 3'd3,
    KIND_ERROR   = 3'd4
  } kind_t;

  // error codes
  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_BAD_ENC  = 2'd1,
    ERR_TOO_LONG = 2'd2,
    ERR_TERM     = 2'd3
  } err_t;

  // encoding bytes with a fixed meaning
  localparam logic [7:0] ENC_STR32 = 8'hF0;
  localparam logic [7:0] ENC_INT16 = 8'hF1;
  localparam logic [7:0] ENC_INT24 = 8'hF2;
  localparam logic [7:0] ENC_INT32 = 8'hF3;
  localparam logic [7:0] ENC_INT64 = 8'hF4;
  localparam logic [7:0] ENC_TERM  = 8'hFF;

  localparam logic [5:0]  STR6_LEN_MASK  = 6'h3F;
  localparam logic [15:0] COUNT_UNKNOWN  = 16'hFFFF;
  localparam logic [31:0] HEADER_LAST    = 32'd5;

  // trailer size break points
  localparam logic [33:0] TS1_MAX = 34'd127;
  localparam logic [33:0] TS2_LIM = 34'd16383;
  localparam logic [33:0] TS3_LIM = 34'd2097151;
  localparam logic [33:0] TS4_LIM = 34'd268435455;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_flag;
  } in_item_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [63:0] int_value;
    logic [31:0]        string_length;
    logic [7:0]         payload_byte;
    logic               last_payload;
    logic [31:0]        entry_offset;
    logic [31:0]        entry_count;
    logic               count_matches;
    err_t               error_code;
  } out_item_t;

  // backlen trailer size for a given entry length
  function automatic logic [2:0] trailer_size(input logic [33:0] len);
    logic [2:0] ts;
    if (len <= TS1_MAX) ts = 3'd1;
    else if (len < TS2_LIM) ts = 3'd2;
    else if (len < TS3_LIM) ts = 3'd3;
    else if (len < TS4_LIM) ts = 3'd4;
    else ts = 3'd5;
    return ts;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/lpk_stream_if.sv
// ----------------------------------------------------------------------------
// lpk_stream_if: valid/ready stream channel
// Carries one payload of type T per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpk_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/listpack_entry_stream_parser_core.sv
// ----------------------------------------------------------------------------
// listpack_entry_stream_parser_core: streaming list blob entry decoder
// Walks header, entries and terminator one byte per transfer and reports
// integers, string headers, payload bytes, end of blob and errors.
// ----------------------------------------------------------------------------
// The parser takes one blob byte per cycle on in_ch and gives at most one
// result per byte on out_ch. Each byte is decoded in the cycle it is taken:
// the phase register and the entry fields update at that edge and any result
// lands in a single output register, so a byte is taken every cycle as long
// as out_ch keeps up (in_ch.ready is low only while a result sits unclaimed
// in the output register). A result is valid the cycle after its byte. The
// longest path is the 32-bit string length of an F0 entry: merge the last
// length byte, add header size, pick the trailer size and compare the entry
// end against the header's total size. A byte with start_flag set restarts
// the parser and is header byte 0; after an end or error result, bytes are
// dropped silently until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module listpack_entry_stream_parser_core
  import lpk_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  lpk_stream_if.sink    in_ch,
  lpk_stream_if.source  out_ch
);

  // --------------------------------------------------------------------------
  // State registers
  // --------------------------------------------------------------------------
  phase_t      phase, phase_next;
  logic [31:0] byte_position, byte_position_next;
  logic [31:0] total_size, total_size_next;
  logic [15:0] header_count, header_count_next;
  logic [31:0] found_count, found_count_next;
  logic [7:0]  encoding_byte, encoding_byte_next;
  logic [63:0] field_accumulator, field_accumulator_next;
  logic [3:0]  field_bytes_left, field_bytes_left_next;
  logic [2:0]  field_index, field_index_next;       // field bytes taken so far
  logic [31:0] payload_left, payload_left_next;
  logic [31:0] string_length, string_length_next;   // length of current string
  logic [2:0]  trailer_left, trailer_left_next;
  logic [31:0] entry_start, entry_start_next;

  // output register
  logic      out_valid;
  out_item_t out_data;

  logic      in_ready;
  logic      in_fire;
  logic      emit;
  out_item_t res;

  assign in_ready     = !out_valid || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ready;
  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  // --------------------------------------------------------------------------
  // Per-byte decode
  // --------------------------------------------------------------------------
  always_comb begin
    logic [7:0]  b;
    logic        start;
    phase_t      cur_phase;
    logic [31:0] cur_pos;
    logic [63:0] cur_acc;
    logic [31:0] cur_found;
    logic [2:0]  shift_idx;
    logic [63:0] acc_merge;
    logic [33:0] pos_ext;
    logic [33:0] tot_ext;
    logic [33:0] enc_need;
    logic [31:0] str_len;
    logic [33:0] str_el;
    logic [2:0]  str_ts;
    logic        str_fits;
    logic [63:0] int_val;

    b         = in_ch.data.data_byte;
    start     = in_ch.data.start_flag;

    // a start byte sees the parser as fresh out of reset
    cur_phase = start ? PH_HEADER : phase;
    cur_pos   = start ? 32'd0 : byte_position;
    cur_acc   = start ? 64'd0 : field_accumulator;
    cur_found = start ? 32'd0 : found_count;

    shift_idx = (cur_phase == PH_HEADER) ? cur_pos[2:0] : field_index;
    acc_merge = cur_acc | ({56'd0, b} << {shift_idx, 3'b000});
    pos_ext   = {2'b00, cur_pos};
    tot_ext   = {2'b00, total_size};
    enc_need  = '0;
    str_len   = '0;
    str_el    = '0;
    str_ts    = 3'd1;
    str_fits  = 1'b0;
    int_val   = '0;

    phase_next             = cur_phase;
    byte_position_next     = cur_pos + 32'd1;
    total_size_next        = total_size;
    header_count_next      = header_count;
    found_count_next       = cur_found;
    encoding_byte_next     = encoding_byte;
    field_accumulator_next = cur_acc;
    field_bytes_left_next  = field_bytes_left;
    field_index_next       = field_index;
    payload_left_next      = payload_left;
    string_length_next     = string_length;
    trailer_left_next      = trailer_left;
    entry_start_next       = entry_start;

    emit = 1'b0;
    res  = '0;

    case (cur_phase)
      PH_HEADER: begin
        field_accumulator_next = acc_merge;
        if (cur_pos >= HEADER_LAST) begin
          total_size_next        = acc_merge[31:0];
          header_count_next      = acc_merge[47:32];
          field_accumulator_next = '0;
          phase_next             = PH_ENC;
        end
      end

      PH_ENC: begin
        entry_start_next       = cur_pos;
        encoding_byte_next     = b;
        field_accumulator_next = '0;
        field_index_next       = '0;
        if (b == ENC_TERM) begin
          emit       = 1'b1;
          phase_next = PH_DONE;
          res.entry_count = cur_found;
          if ({1'b0, cur_pos} + 33'd1 != {1'b0, total_size}) begin
            res.kind       = KIND_ERROR;
            res.error_code = ERR_TERM;
          end else begin
            res.kind          = KIND_END;
            res.count_matches = (header_count == COUNT_UNKNOWN) ||
                                (cur_found == {16'd0, header_count});
          end
        end else if (b inside {[8'h00:8'h7F]}) begin
          // 7-bit int: entry length 1, trailer 1
          emit = 1'b1;
          res.entry_count = cur_found;
          if (pos_ext + 34'd2 < tot_ext) begin
            res.kind          = KIND_INT;
            res.int_value     = $signed({56'd0, b});
            found_count_next  = cur_found + 32'd1;
            trailer_left_next = 3'd1;
            phase_next        = PH_TRAILER;
          end else begin
            res.kind       = KIND_ERROR;
            res.error_code = ERR_TOO_LONG;
            phase_next     = PH_DONE;
          end
        end else if (b inside {[8'h80:8'hBF]}) begin
          // 6-bit string: header 1 + len <= 64, trailer 1
          emit = 1'b1;
          res.entry_count = cur_found;
          if (pos_ext + {28'd0, b[5:0] & STR6_LEN_MASK} + 34'd2 < tot_ext) begin
            res.kind           = KIND_STR_HDR;
            res.string_length  = {26'd0, b[5:0]};
            found_count_next   = cur_found + 32'd1;
            string_length_next = {26'd0, b[5:0]};
            payload_left_next  = {26'd0, b[5:0]};
            trailer_left_next  = 3'd1;
            phase_next         = (b[5:0] != 6'd0) ? PH_PAYLOAD : PH_TRAILER;
          end else begin
            res.kind       = KIND_ERROR;
            res.error_code = ERR_TOO_LONG;
            phase_next     = PH_DONE;
          end
        end else if (b inside {[8'hF5:8'hFE]}) begin
          emit           = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_BAD_ENC;
          res.entry_count = cur_found;
          phase_next     = PH_DONE;
        end else if (b inside {[8'hE0:8'hEF]} || b == ENC_STR32) begin
          // string length follows; fit is checked once it is known
          if (b == ENC_STR32) begin
            field_bytes_left_next = 4'd4;
          end else begin
            field_accumulator_next = {52'd0, b[3:0], 8'd0};
            field_bytes_left_next  = 4'd1;
          end
          phase_next = PH_FIELD;
        end else begin
          // integers with extra bytes: need = entry length + trailer 1
          case (b)
            ENC_INT16: begin
              field_bytes_left_next = 4'd2;
              enc_need              = 34'd4;
            end
            ENC_INT24: begin
              field_bytes_left_next = 4'd3;
              enc_need              = 34'd5;
            end
            ENC_INT32: begin
              field_bytes_left_next = 4'd4;
              enc_need              = 34'd6;
            end
            ENC_INT64: begin
              field_bytes_left_next = 4'd8;
              enc_need              = 34'd10;
            end
            default: begin
              // 13-bit int
              field_accumulator_next = {51'd0, b[4:0], 8'd0};
              field_bytes_left_next  = 4'd1;
              enc_need               = 34'd3;
            end
          endcase
          if (pos_ext + enc_need < tot_ext) begin
            phase_next = PH_FIELD;
          end else begin
            emit            = 1'b1;
            res.kind        = KIND_ERROR;
            res.error_code  = ERR_TOO_LONG;
            res.entry_count = cur_found;
            phase_next      = PH_DONE;
          end
        end
      end

      PH_FIELD: begin
        if ({1'b0, cur_pos} + 33'd1 >= {1'b0, total_size}) begin
          emit            = 1'b1;
          res.kind        = KIND_ERROR;
          res.error_code  = ERR_TOO_LONG;
          res.entry_count = cur_found;
          phase_next      = PH_DONE;
        end else begin
          field_accumulator_next = acc_merge;
          field_bytes_left_next  = field_bytes_left - 4'd1;
          field_index_next       = field_index + 3'd1;
          if (field_bytes_left_next == 4'd0) begin
            emit = 1'b1;
            res.entry_count = cur_found;
            if (encoding_byte == ENC_STR32 || encoding_byte inside {[8'hE0:8'hEF]}) begin
              if (encoding_byte == ENC_STR32) begin
                str_len = acc_merge[31:0];
                str_el  = {2'b00, str_len} + 34'd5;
              end else begin
                str_len = {20'd0, acc_merge[11:0]};
                str_el  = {2'b00, str_len} + 34'd2;
              end
              str_ts   = trailer_size(str_el);
              str_fits = ({2'b00, entry_start} + str_el + {31'd0, str_ts}) < tot_ext;
              if (str_fits) begin
                res.kind           = KIND_STR_HDR;
                res.string_length  = str_len;
                found_count_next   = cur_found + 32'd1;
                string_length_next = str_len;
                payload_left_next  = str_len;
                trailer_left_next  = str_ts;
                phase_next         = (str_len != 32'd0) ? PH_PAYLOAD : PH_TRAILER;
              end else begin
                res.kind       = KIND_ERROR;
                res.error_code = ERR_TOO_LONG;
                phase_next     = PH_DONE;
              end
            end else begin
              case (encoding_byte)
                ENC_INT16: int_val = {{48{acc_merge[15]}}, acc_merge[15:0]};
                ENC_INT24: int_val = {{40{acc_merge[23]}}, acc_merge[23:0]};
                ENC_INT32: int_val = {{32{acc_merge[31]}}, acc_merge[31:0]};
                ENC_INT64: int_val = acc_merge;
                default:   int_val = {{51{acc_merge[12]}}, acc_merge[12:0]};
              endcase
              res.kind          = KIND_INT;
              res.int_value     = $signed(int_val);
              found_count_next  = cur_found + 32'd1;
              trailer_left_next = 3'd1;   // all integer entries fit a 1-byte trailer
              phase_next        = PH_TRAILER;
            end
          end
        end
      end

      PH_PAYLOAD: begin
        payload_left_next = payload_left - 32'd1;
        emit              = 1'b1;
        res.kind          = KIND_PAYLOAD;
        res.string_length = string_length;
        res.payload_byte  = b;
        res.last_payload  = (payload_left_next == 32'd0);
        res.entry_count   = cur_found - 32'd1;
        if (payload_left_next == 32'd0) phase_next = PH_TRAILER;
      end

      PH_TRAILER: begin
        if (trailer_left != 3'd0) trailer_left_next = trailer_left - 3'd1;
        if (trailer_left_next == 3'd0) phase_next = PH_ENC;
      end

      default: begin
        // done: drop bytes until the next start
      end
    endcase

    res.entry_offset = entry_start_next;
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEADER;
      byte_position     <= '0;
      found_count       <= '0;
      field_accumulator <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (in_fire) begin
        phase             <= phase_next;
        byte_position     <= byte_position_next;
        found_count       <= found_count_next;
        field_accumulator <= field_accumulator_next;
        out_valid         <= emit;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload and entry fields, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      total_size       <= total_size_next;
      header_count     <= header_count_next;
      encoding_byte    <= encoding_byte_next;
      field_bytes_left <= field_bytes_left_next;
      field_index      <= field_index_next;
      payload_left     <= payload_left_next;
      string_length    <= string_length_next;
      trailer_left     <= trailer_left_next;
      entry_start      <= entry_start_next;
      if (emit) out_data <= res;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_err_has_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_ERROR |-> out_data.error_code != ERR_NONE)
    else $error("error result without error code");

  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    in_fire && phase == PH_DONE && !in_ch.data.start_flag |=> !out_valid)
    else $error("result produced after end of blob");

  a_payload_emits: assert property (@(posedge clk) disable iff (rst)
    in_fire && phase == PH_PAYLOAD && !in_ch.data.start_flag
      |=> out_valid && out_data.kind == KIND_PAYLOAD)
    else $error("payload byte without payload result");

  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> payload_left != 32'd0)
    else $error("payload phase with no bytes left");

  a_trailer_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_TRAILER |-> trailer_left != 3'd0)
    else $error("trailer phase with no bytes left");

endmodule

`default_nettype wire

>>> tb/tb_listpack_entry_stream_parser_core.sv
// ----------------------------------------------------------------------------
// tb_listpack_entry_stream_parser_core: self-checking bench for the blob parser
// Builds list blobs byte by byte (well-formed, damaged and plain noise), sends
// them over in_ch under varying sender and receiver idling, and checks every
// result on out_ch against a built-in byte-level decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_listpack_entry_stream_parser_core;
  import lpk_pkg::*;

  // encoding byte prefixes used by both the decoder and the builder, and ranges used by the builder
  localparam logic [1:0] PFX_STR6   = 2'b10;
  localparam logic [2:0] PFX_INT13  = 3'b110;
  localparam logic [3:0] PFX_STR12  = 4'hE;
  localparam logic [7:0] ENC_BAD_LO = 8'hF5;
  localparam logic [7:0] ENC_BAD_HI = 8'hFE;
  localparam int         HDR_BYTES  = 6;
  localparam int         MAX_SHOWN  = 10;
  localparam int         RUN_LIMIT  = 400000;
  localparam int         QUARTER    = 250;

  // entry shapes the blob builder can lay down
  typedef enum int {
    F_UINT7, F_INT13, F_INT16, F_INT24, F_INT32, F_INT64, F_STR6, F_STR12, F_STR32
  } form_t;

  // --------------------------------------------------------------------------
  // Scoreboard: byte-level decoder plus the queue of results still owed.
  // --------------------------------------------------------------------------
  class entry_scoreboard;
    phase_t      phase;
    logic [31:0] pos_ctr;
    logic [31:0] total_size;
    logic [15:0] hdr_count;
    logic [31:0] found;
    logic [7:0]  enc;
    logic [63:0] acc;
    logic [3:0]  field_left;
    logic [31:0] pay_left;
    logic [32:0] ent_len;
    logic [2:0]  trl_left;
    logic [31:0] ent_start;
    out_item_t   pending_results[$];
    int          mismatches;

    function new();
      clear_state();
      mismatches = 0;
    endfunction

    function void clear_state();
      phase      = PH_HEADER;
      pos_ctr    = '0;
      total_size = '0;
      hdr_count  = '0;
      found      = '0;
      enc        = '0;
      acc        = '0;
      field_left = '0;
      pay_left   = '0;
      ent_len    = '0;
      trl_left   = '0;
      ent_start  = '0;
    endfunction

    static function logic [2:0] backlen_size(logic [63:0] len);
      if (len <= 64'd127) return 3'd1;
      if (len < 64'd16383) return 3'd2;
      if (len < 64'd2097151) return 3'd3;
      if (len < 64'd268435455) return 3'd4;
      return 3'd5;
    endfunction

    function logic [63:0] sign_extend(logic [63:0] v, int bits);
      logic signed [63:0] t;
      t = $signed(v << (64 - bits));
      return t >>> (64 - bits);
    endfunction

    // entry plus trailer must end before the terminator slot
    function bit entry_fits();
      logic [63:0] last;
      last = 64'(ent_start) + 64'(ent_len) + 64'(backlen_size(64'(ent_len)));
      return last < 64'(total_size);
    endfunction

    function out_item_t make_result(kind_t k, logic [63:0] iv, logic [31:0] slen,
                                    logic [7:0] pb, logic lastp, logic [31:0] cnt,
                                    logic cm, err_t ec);
      out_item_t r;
      r.kind          = k;
      r.int_value     = iv;
      r.string_length = slen;
      r.payload_byte  = pb;
      r.last_payload  = lastp;
      r.entry_offset  = ent_start;
      r.entry_count   = cnt;
      r.count_matches = cm;
      r.error_code    = ec;
      return r;
    endfunction

    function bit fail_with(err_t code, output out_item_t r);
      r = make_result(KIND_ERROR, '0, '0, '0, 1'b0, found, 1'b0, code);
      phase = PH_DONE;
      return 1'b1;
    endfunction

    function bit int_result(logic [63:0] v, output out_item_t r);
      r = make_result(KIND_INT, v, '0, '0, 1'b0, found, 1'b0, ERR_NONE);
      found++;
      trl_left = backlen_size(64'(ent_len));
      phase = PH_TRAILER;
      return 1'b1;
    endfunction

    function bit string_result(logic [31:0] len, logic [2:0] hsz, output out_item_t r);
      ent_len = 33'(len) + 33'(hsz);
      if (!entry_fits()) return fail_with(ERR_TOO_LONG, r);
      r = make_result(KIND_STR_HDR, '0, len, '0, 1'b0, found, 1'b0, ERR_NONE);
      found++;
      pay_left = len;
      trl_left = backlen_size(64'(ent_len));
      phase = (len != 0) ? PH_PAYLOAD : PH_TRAILER;
      return 1'b1;
    endfunction

    // one byte through the decoder; returns 1 when it yields a result
    function bit decode_byte(logic [7:0] b, logic sf, output out_item_t r);
      logic [31:0] p;
      logic [31:0] rel;
      logic [63:0] v;
      logic [32:0] hsz;
      logic        cm;
      r = '0;
      if (sf) clear_state();
      p = pos_ctr;
      pos_ctr = p + 1;
      case (phase)
        PH_HEADER: begin
          acc |= 64'(b) << (8 * p[2:0]);
          if (p >= 5) begin
            total_size = acc[31:0];
            hdr_count  = acc[47:32];
            acc        = '0;
            phase      = PH_ENC;
          end
          return 1'b0;
        end
        PH_ENC: begin
          ent_start = p;
          enc       = b;
          acc       = '0;
          if (b == ENC_TERM) begin
            if (64'(p) + 1 != 64'(total_size)) return fail_with(ERR_TERM, r);
            cm = (hdr_count == COUNT_UNKNOWN) || (found == 32'(hdr_count));
            r = make_result(KIND_END, '0, '0, '0, 1'b0, found, cm, ERR_NONE);
            phase = PH_DONE;
            return 1'b1;
          end
          if (!b[7]) begin
            ent_len = 33'd1;
            if (!entry_fits()) return fail_with(ERR_TOO_LONG, r);
            return int_result(64'(b), r);
          end
          if (b[7:6] == PFX_STR6) return string_result(32'(b[5:0]), 3'd1, r);
          if (b[7:5] == PFX_INT13) begin
            acc = 64'(b[4:0]) << 8;
            field_left = 4'd1;
          end else if (b[7:4] == PFX_STR12) begin
            acc = 64'(b[3:0]) << 8;
            field_left = 4'd1;
          end else if (b == ENC_STR32) field_left = 4'd4;
          else if (b == ENC_INT16) field_left = 4'd2;
          else if (b == ENC_INT24) field_left = 4'd3;
          else if (b == ENC_INT32) field_left = 4'd4;
          else if (b == ENC_INT64) field_left = 4'd8;
          else return fail_with(ERR_BAD_ENC, r);
          // integer sizes are known here; string sizes only after the length
          if (b[7:4] != PFX_STR12 && b != ENC_STR32) begin
            ent_len = 33'(field_left) + 33'd1;
            if (!entry_fits()) return fail_with(ERR_TOO_LONG, r);
          end
          phase = PH_FIELD;
          return 1'b0;
        end
        PH_FIELD: begin
          if (64'(p) + 1 >= 64'(total_size)) return fail_with(ERR_TOO_LONG, r);
          rel = p - ent_start - 1;
          if (enc < ENC_STR32) acc |= 64'(b);
          else acc |= 64'(b) << (8 * rel[2:0]);
          field_left = field_left - 4'd1;
          if (field_left != 0) return 1'b0;
          if (enc == ENC_STR32) return string_result(acc[31:0], 3'd5, r);
          if (enc[7:4] == PFX_STR12) return string_result(32'(acc[11:0]), 3'd2, r);
          if (enc[7:5] == PFX_INT13) v = sign_extend(acc, 13);
          else if (enc == ENC_INT16) v = sign_extend(acc, 16);
          else if (enc == ENC_INT24) v = sign_extend(acc, 24);
          else if (enc == ENC_INT32) v = sign_extend(acc, 32);
          else v = acc;
          return int_result(v, r);
        end
        PH_PAYLOAD: begin
          pay_left--;
          if (enc[7:6] == PFX_STR6) hsz = 33'd1;
          else if (enc[7:4] == PFX_STR12) hsz = 33'd2;
          else hsz = 33'd5;
          r = make_result(KIND_PAYLOAD, '0, 32'(ent_len - hsz), b, pay_left == 0,
                          found - 1, 1'b0, ERR_NONE);
          if (pay_left == 0) phase = PH_TRAILER;
          return 1'b1;
        end
        PH_TRAILER: begin
          if (trl_left > 0) trl_left--;
          if (trl_left == 0) phase = PH_ENC;
          return 1'b0;
        end
        default: return 1'b0;
      endcase
    endfunction

    // accepted input transfer; returns 0 for a byte the parser just drops
    function bit note_byte(in_item_t it);
      out_item_t r;
      bit        live;
      live = it.start_flag || phase != PH_DONE;
      if (decode_byte(it.data_byte, it.start_flag, r)) pending_results.push_back(r);
      return live;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected result: kind %0d off %0d", got.kind, got.entry_offset);
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind || got.int_value !== want.int_value ||
          got.string_length !== want.string_length ||
          got.payload_byte !== want.payload_byte ||
          got.last_payload !== want.last_payload ||
          got.entry_offset !== want.entry_offset ||
          got.entry_count !== want.entry_count ||
          got.count_matches !== want.count_matches ||
          got.error_code !== want.error_code) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
          $display("mismatch exp: kind %0d int %0h len %0d byte %0h last %0b off %0d",
                   want.kind, want.int_value, want.string_length, want.payload_byte,
                   want.last_payload, want.entry_offset);
          $display("             cnt %0d match %0b err %0d",
                   want.entry_count, want.count_matches, want.error_code);
          $display("         got: kind %0d int %0h len %0d byte %0h last %0b off %0d",
                   got.kind, got.int_value, got.string_length, got.payload_byte,
                   got.last_payload, got.entry_offset);
          $display("             cnt %0d match %0b err %0d",
                   got.entry_count, got.count_matches, got.error_code);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels, block under test
  // --------------------------------------------------------------------------
  logic clk;
  logic rst;

  lpk_stream_if #(.T(in_item_t))  in_ch ();
  lpk_stream_if #(.T(out_item_t)) out_ch ();

  listpack_entry_stream_parser_core uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  entry_scoreboard sb;
  int          src_idle_pct  = 0;   // chance that the sender holds valid low before a transfer, drawn anew while idle
  int          snk_stall_pct = 0;   // chance per cycle that the receiver holds ready low
  int          live_bytes    = 0;   // accepted bytes the parser actually looked at
  int unsigned cycle_count   = 0;

  // blob under construction: entries, then the whole blob with header and terminator
  logic [7:0]  body_q[$];
  logic [7:0]  blob_q[$];
  int unsigned entry_offs[$];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog: a hung handshake or a missing result ends here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver: check each result transfer, then pick ready for the next cycle
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
    out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Blob builder
  // --------------------------------------------------------------------------
  function automatic void new_blob();
    body_q = {};
    entry_offs = {};
  endfunction

  function automatic void push_le(logic [63:0] v, int n);
    for (int i = 0; i < n; i++) body_q.push_back(v[8*i +: 8]);
  endfunction

  // v is the integer value, or the payload length for strings
  function automatic void add_entry(form_t f, logic [63:0] v);
    logic [32:0] elen;
    logic [31:0] plen;
    plen = '0;
    entry_offs.push_back(HDR_BYTES + body_q.size());
    case (f)
      F_UINT7: begin
        body_q.push_back({1'b0, v[6:0]});
        elen = 33'd1;
      end
      F_INT13: begin
        body_q.push_back({PFX_INT13, v[12:8]});
        body_q.push_back(v[7:0]);
        elen = 33'd2;
      end
      F_INT16: begin
        body_q.push_back(ENC_INT16);
        push_le(v, 2);
        elen = 33'd3;
      end
      F_INT24: begin
        body_q.push_back(ENC_INT24);
        push_le(v, 3);
        elen = 33'd4;
      end
      F_INT32: begin
        body_q.push_back(ENC_INT32);
        push_le(v, 4);
        elen = 33'd5;
      end
      F_INT64: begin
        body_q.push_back(ENC_INT64);
        push_le(v, 8);
        elen = 33'd9;
      end
      F_STR6: begin
        body_q.push_back({PFX_STR6, v[5:0]});
        plen = 32'(v[5:0]);
        elen = 33'(plen) + 33'd1;
      end
      F_STR12: begin
        body_q.push_back({PFX_STR12, v[11:8]});
        body_q.push_back(v[7:0]);
        plen = 32'(v[11:0]);
        elen = 33'(plen) + 33'd2;
      end
      default: begin
        body_q.push_back(ENC_STR32);
        push_le(v, 4);
        plen = v[31:0];
        elen = 33'(plen) + 33'd5;
      end
    endcase
    repeat (plen) body_q.push_back(8'($urandom));
    // backlen trailer content is not checked by the parser, so fill at random
    repeat (entry_scoreboard::backlen_size(64'(elen))) body_q.push_back(8'($urandom));
  endfunction

  function automatic void make_blob(logic [15:0] cnt);
    logic [31:0] total;
    total = 32'(HDR_BYTES + body_q.size() + 1);
    blob_q = {};
    for (int i = 0; i < 4; i++) blob_q.push_back(total[8*i +: 8]);
    blob_q.push_back(cnt[7:0]);
    blob_q.push_back(cnt[15:8]);
    foreach (body_q[i]) blob_q.push_back(body_q[i]);
    blob_q.push_back(ENC_TERM);
  endfunction

  function automatic logic [31:0] blob_total();
    return {blob_q[3], blob_q[2], blob_q[1], blob_q[0]};
  endfunction

  function automatic void set_total(logic [31:0] t);
    for (int i = 0; i < 4; i++) blob_q[i] = t[8*i +: 8];
  endfunction

  // mostly short strings; now and then one long enough for a two-byte trailer
  function automatic logic [63:0] random_arg(form_t f);
    case (f)
      F_STR6:  return 64'(($urandom_range(3) == 0) ? $urandom_range(63)
                                                   : $urandom_range(6));
      F_STR12: return 64'(($urandom_range(15) == 0) ? $urandom_range(128, 300)
                                                    : $urandom_range(10));
      F_STR32: return 64'($urandom_range(8));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic sf);
    in_item_t item;
    item.data_byte  = b;
    item.start_flag = sf;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= item;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (sb.note_byte(item)) live_bytes++;
  endtask

  task automatic send_blob(input bit with_start);
    foreach (blob_q[i]) send_byte(blob_q[i], with_start && i == 0);
  endtask

  // sender holds off until every owed result has been taken
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    logic [31:0] big_lens[4];
    big_lens = '{32'hFFFF_FFFF, 32'd20000, 32'd3000000, 32'd300000000};

    // right out of reset with no start flag: parsed as a blob anyway
    new_blob();
    add_entry(F_UINT7, 64'd0);
    add_entry(F_UINT7, 64'd127);
    make_blob(16'd2);
    send_blob(1'b0);

    // empty blob, count matches
    new_blob();
    make_blob(16'd0);
    send_blob(1'b1);

    // each multi-byte integer width at an extreme, header count unknown
    new_blob();
    add_entry(F_INT13, 64'h1000);
    add_entry(F_INT13, 64'h0FFF);
    add_entry(F_INT16, 64'h8000);
    add_entry(F_INT24, 64'h7F_FFFF);
    add_entry(F_INT32, 64'h8000_0000);
    add_entry(F_INT64, 64'h8000_0000_0000_0000);
    add_entry(F_INT64, 64'h7FFF_FFFF_FFFF_FFFF);
    make_blob(COUNT_UNKNOWN);
    send_blob(1'b1);

    // strings of each form, header count wrong, then bytes after the end dropped
    new_blob();
    add_entry(F_STR6, 64'd0);
    add_entry(F_STR6, 64'd63);
    add_entry(F_STR12, 64'd130);
    add_entry(F_STR32, 64'd1);
    make_blob(16'd5);
    blob_q.push_back(8'h01);
    blob_q.push_back(8'h80);
    send_blob(1'b1);

    // lowest and highest unknown encoding byte
    for (int i = 0; i < 2; i++) begin
      new_blob();
      add_entry(F_UINT7, 64'd5);
      add_entry(F_UINT7, 64'd6);
      make_blob(16'd2);
      blob_q[entry_offs[1]] = (i == 0) ? ENC_BAD_LO : ENC_BAD_HI;
      send_blob(1'b1);
    end

    // entry runs one byte past the size: caught at the encoding byte
    new_blob();
    add_entry(F_INT64, 64'd1);
    make_blob(16'd1);
    set_total(blob_total() - 1);
    send_blob(1'b1);

    new_blob();
    add_entry(F_STR6, 64'd3);
    make_blob(16'd1);
    set_total(blob_total() - 1);
    send_blob(1'b1);

    // terminator one byte early relative to the header size
    new_blob();
    add_entry(F_UINT7, 64'd9);
    make_blob(16'd1);
    set_total(blob_total() + 1);
    send_blob(1'b1);

    // 12-bit string whose length byte sits on the last offset
    new_blob();
    add_entry(F_STR12, 64'd0);
    make_blob(16'd1);
    set_total(32'd8);
    send_blob(1'b1);

    // 32-bit lengths: one too long for any size, then trailer sizes 3..5,
    // each cut short by the next start flag
    foreach (big_lens[k]) begin
      new_blob();
      body_q.push_back(ENC_STR32);
      push_le(64'(big_lens[k]), 4);
      repeat (3) body_q.push_back(8'($urandom));
      make_blob(16'd0);
      set_total(32'hFFFF_FFFF);
      void'(blob_q.pop_back());
      send_blob(1'b1);
    end
  endtask

  // one random sequence: mostly well-formed blobs, some damaged, some noise
  task automatic send_random_sequence();
    int          pick;
    int          n;
    int          k;
    form_t       f;
    logic [15:0] cnt;
    logic [31:0] total;
    pick = $urandom_range(99);
    if (pick < 85) begin
      new_blob();
      n = $urandom_range(6);
      repeat (n) begin
        f = form_t'($urandom_range(8));
        add_entry(f, random_arg(f));
      end
      k = $urandom_range(99);
      cnt = (k < 70) ? 16'(n) : (k < 85) ? COUNT_UNKNOWN : 16'($urandom);
      make_blob(cnt);
      if (pick >= 70) begin
        total = blob_total();
        case ($urandom_range(5))
          0: set_total(total - $urandom_range(1, total - 1));
          1: set_total(total + $urandom_range(1, 9));
          2: if (entry_offs.size() != 0)
               blob_q[entry_offs[$urandom_range(entry_offs.size() - 1)]] =
                 8'($urandom_range(ENC_BAD_LO, ENC_BAD_HI));
          3: if (entry_offs.size() != 0)
               blob_q[entry_offs[$urandom_range(entry_offs.size() - 1)]] = ENC_TERM;
          4: repeat ($urandom_range(1, blob_q.size() - 1)) void'(blob_q.pop_back());
          default: blob_q[$urandom_range(blob_q.size() - 1)] = 8'($urandom);
        endcase
      end
      send_blob(1'b1);
    end else begin
      // raw noise, sometimes with restarts in the middle
      n = $urandom_range(1, 16);
      for (int i = 0; i < n; i++)
        send_byte(8'($urandom), (i == 0) ? 1'($urandom_range(1)) : ($urandom_range(7) == 0));
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    rst          = 1'b1;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    drain_results();

    // four idling regimes: none, sender gaps, receiver stalls, both
    live_bytes = 0;
    for (int q = 0; q < 4; q++) begin
      src_idle_pct  = (q == 1) ? 54 : (q == 3) ? 30 : 0;
      snk_stall_pct = (q == 2) ? 54 : (q == 3) ? 30 : 0;
      while (live_bytes < (q + 1) * QUARTER) send_random_sequence();
      drain_results();
    end

    // room for any stray late result to show up
    repeat (16) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
